// File: rtl/assert_macros.svh
// assertion macros used by the checker file
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define Q2E_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// consequent holds in the same cycle as the antecedent
`define Q2E_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// consequent holds in the cycle after the antecedent
`define Q2E_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/q2e_pkg.sv
// shared constants and the arctangent table of the quaternion to euler block
// no dependencies
package q2e_pkg;

    localparam int QUAT_FRAC_BITS  = 14;
    localparam int ANGLE_FRAC_BITS = 13;
    localparam int ACC_BITS        = 30;
    localparam int CORDIC_STEPS    = 31;
    localparam int SQRT_STEPS      = 31;
    localparam int NORM_STEPS      = 6;
    localparam int OPER_W          = 40;
    localparam int CORD_W          = 43;
    localparam int ANG_W           = 33;
    localparam int SUM_W           = 35;
    localparam int RAD_W           = 62;
    localparam int ATAN_LAT        = 1 + NORM_STEPS + CORDIC_STEPS + 1;
    localparam int ROUND_SHIFT     = ACC_BITS - ANGLE_FRAC_BITS;

    localparam logic [31:0] PI_Q30      = 32'd3373259426;
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

    // atan(2^-i) in Q30
    function automatic logic [29:0] atan_entry(input int idx);
        logic [29:0] val;
        case (idx)
            0:       val = 30'd843314856;
            1:       val = 30'd497837829;
            2:       val = 30'd263043836;
            3:       val = 30'd133525158;
            4:       val = 30'd67021686;
            5:       val = 30'd33543515;
            6:       val = 30'd16775850;
            7:       val = 30'd8388437;
            8:       val = 30'd4194282;
            9:       val = 30'd2097149;
            10:      val = 30'd1048575;
            11:      val = 30'd524287;
            12:      val = 30'd262143;
            13:      val = 30'd131071;
            14:      val = 30'd65535;
            15:      val = 30'd32767;
            16:      val = 30'd16383;
            17:      val = 30'd8191;
            18:      val = 30'd4095;
            19:      val = 30'd2047;
            20:      val = 30'd1023;
            21:      val = 30'd511;
            22:      val = 30'd255;
            23:      val = 30'd127;
            24:      val = 30'd63;
            25:      val = 30'd31;
            26:      val = 30'd15;
            27:      val = 30'd8;
            28:      val = 30'd4;
            29:      val = 30'd2;
            30:      val = 30'd1;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

// File: rtl/q2e_delay.sv
// fixed-length delay line that advances with the pipeline enable
// depends on nothing
module q2e_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             clk,
    input  logic             en,
    input  logic [WIDTH-1:0] din,
    output logic [WIDTH-1:0] dout
);

    logic [WIDTH-1:0] tap_reg [DEPTH];

    // shift one place per enabled cycle
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tap_reg[0] <= din;
            for (int i = 1; i < DEPTH; i++)
            begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign dout = tap_reg[DEPTH-1];

endmodule

// File: rtl/q2e_cordic_cell.sv
// one vectoring step of the cordic arctangent chain
// depends on q2e_pkg
module q2e_cordic_cell #(
    parameter int STEP  = 0,
    parameter int TAG_W = 1
) (
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [q2e_pkg::CORD_W-1:0]   x_in,
    input  logic signed [q2e_pkg::CORD_W-1:0]   y_in,
    input  logic signed [q2e_pkg::ANG_W-1:0]    z_in,
    input  logic        [TAG_W-1:0]             tag_in,
    output logic signed [q2e_pkg::CORD_W-1:0]   x_out,
    output logic signed [q2e_pkg::CORD_W-1:0]   y_out,
    output logic signed [q2e_pkg::ANG_W-1:0]    z_out,
    output logic        [TAG_W-1:0]             tag_out
);

    localparam logic signed [q2e_pkg::ANG_W-1:0] STEP_ANGLE =
        $signed({3'b000, q2e_pkg::atan_entry(STEP)});

    logic signed [q2e_pkg::CORD_W-1:0] x_sh;
    logic signed [q2e_pkg::CORD_W-1:0] y_sh;

    // arithmetic shifts round toward minus infinity
    assign x_sh = x_in >>> STEP;
    assign y_sh = y_in >>> STEP;

    // rotate toward the x axis
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tag_out <= tag_in;
            if (y_in > 0)
            begin
                x_out <= x_in + y_sh;
                y_out <= y_in - x_sh;
                z_out <= z_in + STEP_ANGLE;
            end
            else
            begin
                x_out <= x_in - y_sh;
                y_out <= y_in + x_sh;
                z_out <= z_in - STEP_ANGLE;
            end
        end
    end

endmodule

// File: rtl/q2e_sqrt_cell.sv
// one digit step of the restoring integer square root chain
// depends on q2e_pkg
module q2e_sqrt_cell #(
    parameter int STEP = 0
) (
    input  logic                         clk,
    input  logic                         en,
    input  logic [q2e_pkg::RAD_W-1:0]    r_in,
    input  logic [q2e_pkg::RAD_W-1:0]    v_in,
    output logic [q2e_pkg::RAD_W-1:0]    r_out,
    output logic [q2e_pkg::RAD_W-1:0]    v_out
);

    localparam logic [q2e_pkg::RAD_W-1:0] BIT_VAL =
        q2e_pkg::RAD_W'(1) << (2 * q2e_pkg::SQRT_STEPS - 2 - 2 * STEP);

    logic [q2e_pkg::RAD_W-1:0] trial;

    assign trial = r_in + BIT_VAL;

    // compare, subtract and shift in the next root bit
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (v_in >= trial)
            begin
                v_out <= v_in - trial;
                r_out <= (r_in >> 1) + BIT_VAL;
            end
            else
            begin
                v_out <= v_in;
                r_out <= r_in >> 1;
            end
        end
    end

endmodule

// File: rtl/q2e_atan.sv
// first-quadrant arctangent: entry, normalizing shifts, cordic chain, clamp
// depends on q2e_pkg, q2e_cordic_cell
module q2e_atan #(
    parameter int TAG_W = 1
) (
    input  logic                          clk,
    input  logic                          en,
    input  logic [q2e_pkg::OPER_W-1:0]    ax,
    input  logic [q2e_pkg::OPER_W-1:0]    ay,
    input  logic [TAG_W-1:0]              tag_in,
    output logic [30:0]                   angle,
    output logic [TAG_W-1:0]              tag_out
);

    localparam int NS = q2e_pkg::NORM_STEPS;
    localparam int CS = q2e_pkg::CORDIC_STEPS;
    localparam int FW = TAG_W + 2;

    logic [q2e_pkg::OPER_W-1:0] nax_reg [NS+1];
    logic [q2e_pkg::OPER_W-1:0] nay_reg [NS+1];
    logic [q2e_pkg::OPER_W-1:0] nmx_reg [NS+1];
    logic [FW-1:0]              nfl_reg [NS+1];

    logic signed [q2e_pkg::CORD_W-1:0] cx [CS+1];
    logic signed [q2e_pkg::CORD_W-1:0] cy [CS+1];
    logic signed [q2e_pkg::ANG_W-1:0]  cz [CS+1];
    logic        [FW-1:0]              cf [CS+1];

    logic [30:0]      angle_reg;
    logic [TAG_W-1:0] tag_reg;

    // entry: larger operand and zero flags (flag bit 1: ay zero, bit 0: ax zero)
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nax_reg[0] <= ax;
            nay_reg[0] <= ay;
            nmx_reg[0] <= (ax > ay) ? ax : ay;
            nfl_reg[0] <= {tag_in, (ay == '0), (ax == '0)};
        end
    end

    // normalize so the larger operand has its top bit set
    for (genvar k = 0; k < NS; k++)
    begin : g_norm
        localparam int SH = (1 << (NS - 1)) >> k;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                nfl_reg[k+1] <= nfl_reg[k];
                if (nmx_reg[k][q2e_pkg::OPER_W-1 -: SH] == '0)
                begin
                    nax_reg[k+1] <= nax_reg[k] << SH;
                    nay_reg[k+1] <= nay_reg[k] << SH;
                    nmx_reg[k+1] <= nmx_reg[k] << SH;
                end
                else
                begin
                    nax_reg[k+1] <= nax_reg[k];
                    nay_reg[k+1] <= nay_reg[k];
                    nmx_reg[k+1] <= nmx_reg[k];
                end
            end
        end
    end

    assign cx[0] = $signed({{(q2e_pkg::CORD_W - q2e_pkg::OPER_W){1'b0}}, nax_reg[NS]});
    assign cy[0] = $signed({{(q2e_pkg::CORD_W - q2e_pkg::OPER_W){1'b0}}, nay_reg[NS]});
    assign cz[0] = '0;
    assign cf[0] = nfl_reg[NS];

    // vectoring chain
    for (genvar i = 0; i < CS; i++)
    begin : g_cordic
        q2e_cordic_cell #(
            .STEP  (i),
            .TAG_W (FW)
        ) u_cell (
            .clk     (clk),
            .en      (en),
            .x_in    (cx[i]),
            .y_in    (cy[i]),
            .z_in    (cz[i]),
            .tag_in  (cf[i]),
            .x_out   (cx[i+1]),
            .y_out   (cy[i+1]),
            .z_out   (cz[i+1]),
            .tag_out (cf[i+1])
        );
    end

    // zero operands, then clamp to the first quadrant
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tag_reg <= cf[CS][FW-1:2];
            if (cf[CS][1])
            begin
                angle_reg <= '0;
            end
            else if (cf[CS][0])
            begin
                angle_reg <= q2e_pkg::HALF_PI_Q30;
            end
            else if (cz[CS][q2e_pkg::ANG_W-1])
            begin
                angle_reg <= '0;
            end
            else if (cz[CS] > $signed({2'b00, q2e_pkg::HALF_PI_Q30}))
            begin
                angle_reg <= q2e_pkg::HALF_PI_Q30;
            end
            else
            begin
                angle_reg <= cz[CS][30:0];
            end
        end
    end

    assign angle   = angle_reg;
    assign tag_out = tag_reg;

endmodule

// File: rtl/quaternion_to_euler_angles.sv
// top level: quaternion to zyx euler angles (roll, pitch, yaw)
// depends on q2e_pkg, q2e_delay, q2e_sqrt_cell, q2e_atan
//
// Takes one Q1.14 quaternion per item and returns roll, pitch and yaw in
// Q2.13 radians (pitch in Q1.13) plus a flag that the pitch sine was saturated to magnitude
// one. The block accepts one item per cycle unless the output buffer is full.
// The pipeline depth is set by the pitch path, which runs a 31-stage
// square-root chain and then a 39-stage arctangent chain in series; roll and
// yaw are delayed to line up with it.
// A two-entry output buffer keeps input ready high while a single result waits.
module quaternion_to_euler_angles (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // q_w, q_x, q_y, q_z
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // roll_angle, pitch_angle, yaw_angle, zero pad
    output logic        m_axis_tuser    // sine_clamped
);

    localparam int SW      = q2e_pkg::SUM_W;
    localparam int OW      = q2e_pkg::OPER_W;
    localparam int LAT     = 2 + 3 + q2e_pkg::SQRT_STEPS + q2e_pkg::ATAN_LAT + 1;
    localparam int RY_DLY  = LAT - (2 + q2e_pkg::ATAN_LAT + 1);
    localparam int FLG_DLY = q2e_pkg::SQRT_STEPS + 2;
    localparam int RS      = q2e_pkg::ROUND_SHIFT;
    localparam logic signed [SW-1:0] ONE_Q = SW'(1) <<< (2 * q2e_pkg::QUAT_FRAC_BITS);

    typedef struct packed {
        logic [15:0] roll;
        logic [14:0] pitch;
        logic [15:0] yaw;
        logic        clamped;
    } result_t;

    // magnitude of a signed sum
    function automatic logic [SW-1:0] mag(input logic signed [SW-1:0] v);
        return v[SW-1] ? SW'(-v) : v;
    endfunction

    // quadrant fix and round half away from zero
    function automatic logic [15:0] to_angle(input logic [30:0] z, input logic xneg,
                                             input logic yneg);
        logic [31:0] m;
        logic [32:0] r;
        logic [15:0] q;
        m = xneg ? (q2e_pkg::PI_Q30 - {1'b0, z}) : {1'b0, z};
        r = {1'b0, m} + (33'd1 << (RS - 1));
        q = 16'(r >> RS);
        return yneg ? 16'(-q) : q;
    endfunction

    logic en;
    logic [LAT-1:0] vld_reg;

    logic signed [31:0] p_wx_reg, p_yz_reg, p_xx_reg, p_yy_reg, p_wz_reg;
    logic signed [31:0] p_xy_reg, p_zz_reg, p_wy_reg, p_zx_reg;
    logic signed [SW-1:0] rn_reg, rd_reg, yn_reg, yd_reg, s_reg;

    logic [SW-1:0] sm;
    logic          clp3_next;
    logic [30:0]   m3_reg, m4_reg, m5_reg, m_dly;
    logic          neg3_reg, clp3_reg;
    logic [61:0]   msq_reg, v5_reg;
    logic [1:0]    pflag_dly;

    logic [q2e_pkg::RAD_W-1:0] sr [q2e_pkg::SQRT_STEPS+1];
    logic [q2e_pkg::RAD_W-1:0] sv [q2e_pkg::SQRT_STEPS+1];

    logic [30:0] roll_z, yaw_z, pitch_z;
    logic [1:0]  roll_t, yaw_t, pitch_t;
    logic [15:0] roll_post_reg, yaw_post_reg, roll_dly, yaw_dly;
    logic [14:0] pitch_post_reg;
    logic        clp_post_reg;

    result_t pipe_res;
    result_t head_reg, head_next, skid_reg, skid_next;
    logic    head_valid_reg, head_valid_next, skid_valid_reg, skid_valid_next;
    logic    push, pop;

    // the pipeline moves unless the output buffer is full
    assign en            = !skid_valid_reg;
    assign s_axis_tready = en;

    // item valid bits down the pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAT-2:0], s_axis_tvalid};
        end
    end

    // products of the quaternion components
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_wx_reg <= $signed(s_axis_tdata[15:0])  * $signed(s_axis_tdata[31:16]);
            p_yz_reg <= $signed(s_axis_tdata[47:32]) * $signed(s_axis_tdata[63:48]);
            p_xx_reg <= $signed(s_axis_tdata[31:16]) * $signed(s_axis_tdata[31:16]);
            p_yy_reg <= $signed(s_axis_tdata[47:32]) * $signed(s_axis_tdata[47:32]);
            p_wz_reg <= $signed(s_axis_tdata[15:0])  * $signed(s_axis_tdata[63:48]);
            p_xy_reg <= $signed(s_axis_tdata[31:16]) * $signed(s_axis_tdata[47:32]);
            p_zz_reg <= $signed(s_axis_tdata[63:48]) * $signed(s_axis_tdata[63:48]);
            p_wy_reg <= $signed(s_axis_tdata[15:0])  * $signed(s_axis_tdata[47:32]);
            p_zx_reg <= $signed(s_axis_tdata[63:48]) * $signed(s_axis_tdata[31:16]);
        end
    end

    // numerators, denominators and the pitch sine
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rn_reg <= (SW'(p_wx_reg) + SW'(p_yz_reg)) <<< 1;
            rd_reg <= ONE_Q - ((SW'(p_xx_reg) + SW'(p_yy_reg)) <<< 1);
            yn_reg <= (SW'(p_wz_reg) + SW'(p_xy_reg)) <<< 1;
            yd_reg <= ONE_Q - ((SW'(p_yy_reg) + SW'(p_zz_reg)) <<< 1);
            s_reg  <= (SW'(p_wy_reg) - SW'(p_zx_reg)) <<< 1;
        end
    end

    // saturate the sine magnitude and bring it to Q30
    assign sm        = mag(s_reg);
    assign clp3_next = sm > SW'(ONE_Q);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            neg3_reg <= s_reg[SW-1];
            clp3_reg <= clp3_next;
            m3_reg   <= (clp3_next ? 31'(ONE_Q) : 31'(sm))
                        << (q2e_pkg::ACC_BITS - 2 * q2e_pkg::QUAT_FRAC_BITS);
            m4_reg   <= m3_reg;
            msq_reg  <= m3_reg * m3_reg;
            m5_reg   <= m4_reg;
            v5_reg   <= (62'd1 << (2 * q2e_pkg::ACC_BITS)) - msq_reg;
        end
    end

    // cosine by square root, one root bit per cell
    assign sr[0] = '0;
    assign sv[0] = v5_reg;

    for (genvar i = 0; i < q2e_pkg::SQRT_STEPS; i++)
    begin : g_sqrt
        q2e_sqrt_cell #(
            .STEP (i)
        ) u_cell (
            .clk   (clk),
            .en    (en),
            .r_in  (sr[i]),
            .v_in  (sv[i]),
            .r_out (sr[i+1]),
            .v_out (sv[i+1])
        );
    end

    q2e_delay #(
        .WIDTH (31),
        .DEPTH (q2e_pkg::SQRT_STEPS)
    ) u_m_dly (
        .clk  (clk),
        .en   (en),
        .din  (m5_reg),
        .dout (m_dly)
    );

    q2e_delay #(
        .WIDTH (2),
        .DEPTH (FLG_DLY)
    ) u_flag_dly (
        .clk  (clk),
        .en   (en),
        .din  ({neg3_reg, clp3_reg}),
        .dout (pflag_dly)
    );

    // roll, yaw and pitch arctangent chains
    q2e_atan #(
        .TAG_W (2)
    ) u_roll (
        .clk     (clk),
        .en      (en),
        .ax      (OW'(mag(rd_reg))),
        .ay      (OW'(mag(rn_reg))),
        .tag_in  ({rd_reg[SW-1], rn_reg[SW-1]}),
        .angle   (roll_z),
        .tag_out (roll_t)
    );

    q2e_atan #(
        .TAG_W (2)
    ) u_yaw (
        .clk     (clk),
        .en      (en),
        .ax      (OW'(mag(yd_reg))),
        .ay      (OW'(mag(yn_reg))),
        .tag_in  ({yd_reg[SW-1], yn_reg[SW-1]}),
        .angle   (yaw_z),
        .tag_out (yaw_t)
    );

    q2e_atan #(
        .TAG_W (2)
    ) u_pitch (
        .clk     (clk),
        .en      (en),
        .ax      (OW'(sr[q2e_pkg::SQRT_STEPS][30:0])),
        .ay      (OW'(m_dly)),
        .tag_in  (pflag_dly),
        .angle   (pitch_z),
        .tag_out (pitch_t)
    );

    // quadrant mapping and rounding
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            roll_post_reg  <= to_angle(roll_z, roll_t[1], roll_t[0]);
            yaw_post_reg   <= to_angle(yaw_z, yaw_t[1], yaw_t[0]);
            pitch_post_reg <= 15'(to_angle(pitch_z, 1'b0, pitch_t[1]));
            clp_post_reg   <= pitch_t[0];
        end
    end

    q2e_delay #(
        .WIDTH (32),
        .DEPTH (RY_DLY)
    ) u_ry_dly (
        .clk  (clk),
        .en   (en),
        .din  ({roll_post_reg, yaw_post_reg}),
        .dout ({roll_dly, yaw_dly})
    );

    assign pipe_res = '{roll: roll_dly, pitch: pitch_post_reg, yaw: yaw_dly,
                        clamped: clp_post_reg};

    // two-entry output buffer
    assign push = en && vld_reg[LAT-1];
    assign pop  = head_valid_reg && m_axis_tready;

    always_comb
    begin
        head_next       = head_reg;
        skid_next       = skid_reg;
        head_valid_next = head_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                head_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                head_next       = pipe_res;
                head_valid_next = push;
            end
        end
        else if (push)
        begin
            if (!head_valid_reg)
            begin
                head_next       = pipe_res;
                head_valid_next = 1'b1;
            end
            else
            begin
                skid_next       = pipe_res;
                skid_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            head_valid_reg <= head_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

    assign m_axis_tvalid = head_valid_reg;
    assign m_axis_tdata  = {1'b0, head_reg.yaw, head_reg.pitch, head_reg.roll};
    assign m_axis_tuser  = head_reg.clamped;

endmodule

// File: rtl/q2e_checker.sv
// port-level checks of the quaternion to euler block, bound to the top level
// depends on assert_macros.svh and quaternion_to_euler_angles
`include "assert_macros.svh"

module q2e_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [63:0] s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    logic signed [14:0] pitch;

    assign pitch = $signed(m_axis_tdata[30:16]);

    // a stalled item stays offered
    `Q2E_ASSERT_NEXT(a_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)

    // input only blocks while results are waiting
    `Q2E_ASSERT_IMPLIES(a_ready, clk, rst_n, !s_axis_tready, m_axis_tvalid)

    // pitch stays within plus or minus pi/2
    `Q2E_ASSERT_ALWAYS(a_pitch_rng, clk, rst_n, !m_axis_tvalid || (pitch <= 15'sd12868 && pitch >= -15'sd12868))

    // a saturated sine gives pitch of exactly plus or minus pi/2
    `Q2E_ASSERT_IMPLIES(a_clamp, clk, rst_n, m_axis_tvalid && m_axis_tuser, pitch == 15'sd12868 || pitch == -15'sd12868)

endmodule

bind quaternion_to_euler_angles q2e_checker u_q2e_checker (.*);

// File: sim/tb.sv
// self-checking testbench for quaternion_to_euler_angles: directed and random quaternions,
// predicted roll/pitch/yaw and clamp flag compared per item; depends on the block's rtl
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint ONE_Q28     = 64'sd1 << 28;
    localparam longint PI_Q30      = 64'sd3373259426;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam int     ROT_STEPS   = 31;
    localparam int     END_WAIT    = 100;

    localparam longint ATAN_Q30 [ROT_STEPS] = '{
        843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
        131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255,
        127, 63, 31, 15, 8, 4, 2, 1
    };

    typedef struct packed {
        logic [15:0] roll;
        logic [14:0] pitch;
        logic [15:0] yaw;
        logic        clamped;
    } euler_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;   // q_w, q_x, q_y, q_z
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;   // roll_angle, pitch_angle, yaw_angle, zero pad
    logic        m_axis_tuser;   // sine_clamped

    euler_t angles_due[$];
    int     error_count;
    int     send_idle_pct;
    int     sink_stall_pct;

    quaternion_to_euler_angles dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // first-quadrant arctangent in q30
    function automatic longint cordic_atan(input longint unsigned ax, input longint unsigned ay);
        longint unsigned mx;
        longint xv, yv, zv, nx;
        zv = 0;
        if (ay == 0)
            return 0;
        if (ax == 0)
            return HALF_PI_Q30;
        mx = (ax > ay) ? ax : ay;
        while (mx >= (64'd1 << 40))
        begin
            ax = ax >> 1; ay = ay >> 1; mx = mx >> 1;
        end
        while (mx < (64'd1 << 39))
        begin
            ax = ax << 1; ay = ay << 1; mx = mx << 1;
        end
        xv = longint'(ax);
        yv = longint'(ay);
        for (int i = 0; i < ROT_STEPS; i++)
        begin
            if (yv > 0)
            begin
                nx = xv + (yv >>> i);
                yv = yv - (xv >>> i);
                zv += ATAN_Q30[i];
            end
            else
            begin
                nx = xv - (yv >>> i);
                yv = yv + (xv >>> i);
                zv -= ATAN_Q30[i];
            end
            xv = nx;
        end
        if (zv < 0)
            zv = 0;
        if (zv > HALF_PI_Q30)
            zv = HALF_PI_Q30;
        return zv;
    endfunction

    function automatic longint unsigned magnitude(input longint v);
        return (v < 0) ? longint'(-v) : longint'(v);
    endfunction

    // four-quadrant arctangent in q30
    function automatic longint quad_atan2(input longint yv, input longint xv);
        longint a;
        if (xv == 0 && yv == 0)
            return 0;
        a = cordic_atan(magnitude(xv), magnitude(yv));
        if (xv < 0)
            a = PI_Q30 - a;
        if (yv < 0)
            a = -a;
        return a;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // q30 radians to q2.13, half away from zero
    function automatic logic [15:0] to_q213(input longint a);
        longint unsigned m;
        m = (magnitude(a) + (64'd1 << 16)) >> 17;
        if (a < 0)
            m = -m;
        return m[15:0];
    endfunction

    function automatic euler_t zyx_angles(input logic [63:0] quat);
        logic signed [15:0] w16, x16, y16, z16;
        longint w, x, y, z, sine, pitch;
        longint unsigned sm, m, c;
        logic [15:0] p16;
        euler_t e;
        {z16, y16, x16, w16} = quat;
        w = w16; x = x16; y = y16; z = z16;
        sine = 2 * (w * y - z * x);
        sm = magnitude(sine);
        e.clamped = (sm > ONE_Q28);
        if (e.clamped)
            sm = ONE_Q28;
        m = sm << 2;
        c = int_sqrt((64'd1 << 60) - m * m);
        pitch = (m == 0) ? 0 : cordic_atan(c, m);
        if (sine < 0)
            pitch = -pitch;
        e.roll = to_q213(quad_atan2(2 * (w * x + y * z), ONE_Q28 - 2 * (x * x + y * y)));
        p16 = to_q213(pitch);
        e.pitch = p16[14:0];
        e.yaw = to_q213(quad_atan2(2 * (w * z + x * y), ONE_Q28 - 2 * (y * y + z * z)));
        return e;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
        error_count++;
    endtask

    // send one item; called at a falling edge, returns at a falling edge
    task automatic send_quat(input logic [15:0] w, x, y, z);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {z, y, x, w};
        do
            @(posedge clk);
        while (!s_axis_tready);
        angles_due.push_back(zyx_angles({z, y, x, w}));
        @(negedge clk);
        if ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    task automatic idle_input();
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
    endtask

    // receiver backpressure
    always @(negedge clk)
        if (rst_n)
            m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);

    // result checker
    always @(posedge clk)
    begin
        euler_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (angles_due.size() == 0)
                report_mismatch("unexpected item", 32'(m_axis_tdata), 0);
            else
            begin
                want = angles_due.pop_front();
                if (m_axis_tdata[15:0] !== want.roll)
                    report_mismatch("roll", m_axis_tdata[15:0], want.roll);
                if (m_axis_tdata[30:16] !== want.pitch)
                    report_mismatch("pitch", m_axis_tdata[30:16], want.pitch);
                if (m_axis_tdata[46:31] !== want.yaw)
                    report_mismatch("yaw", m_axis_tdata[46:31], want.yaw);
                if (m_axis_tuser !== want.clamped)
                    report_mismatch("sine_clamped", m_axis_tuser, want.clamped);
            end
        end
    end

    // extremes, axis rotations, gimbal lock and the clamp
    task automatic test_directed();
        send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_quat(16'sd16384, 16'sd0, 16'sd0, 16'sd0);
        send_quat(-16'sd16384, 16'sd0, 16'sd0, 16'sd0);
        send_quat(16'sd0, 16'sd16384, 16'sd0, 16'sd0);
        send_quat(16'sd0, 16'sd0, 16'sd16384, 16'sd0);
        send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd16384);
        send_quat(16'sd11585, 16'sd0, 16'sd11585, 16'sd0);
        send_quat(16'sd11586, 16'sd0, 16'sd11586, 16'sd0);
        send_quat(16'sd11585, 16'sd0, -16'sd11585, 16'sd0);
        send_quat(16'sd0, 16'sd11586, 16'sd0, 16'sd11586);
        send_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_quat(16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
        send_quat(16'h8000, 16'h0000, 16'h7fff, 16'h0000);
        send_quat(16'sd11585, 16'sd11585, 16'sd0, 16'sd0);
        send_quat(16'sd11585, 16'sd0, 16'sd0, -16'sd11585);
        send_quat(16'sd1, -16'sd1, 16'sd1, -16'sd1);
        send_quat(16'hffff, 16'hffff, 16'hffff, 16'hffff);
        send_quat(16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192);
        send_quat(16'sd0, 16'sd10000, 16'sd0, -16'sd10000);
    endtask

    // mostly unit quaternions, plus raw noise and sparse ones
    task automatic test_random(input int count, input int idle_pct, input int stall_pct,
                               input bit drain_midway);
        real c [4];
        real n;
        logic [15:0] q [4];
        int kind;
        send_idle_pct  = idle_pct;
        sink_stall_pct = stall_pct;
        for (int k = 0; k < count; k++)
        begin
            if (drain_midway && k == count / 2)
            begin
                idle_input();
                wait (angles_due.size() == 0);
                @(negedge clk);
            end
            kind = $urandom_range(99);
            if (kind < 60)
            begin
                n = 0.0;
                for (int j = 0; j < 4; j++)
                begin
                    c[j] = real'(int'($urandom_range(2000)) - 1000);
                    n += c[j] * c[j];
                end
                if (n == 0.0)
                    n = 1.0;
                for (int j = 0; j < 4; j++)
                    q[j] = 16'($rtoi(c[j] * 16384.0 / $sqrt(n)) + $urandom_range(4) - 2);
            end
            else if (kind < 85)
            begin
                for (int j = 0; j < 4; j++)
                    q[j] = 16'($urandom);
            end
            else
            begin
                for (int j = 0; j < 4; j++)
                    q[j] = ($urandom_range(1) == 0) ? 16'h0 : 16'($urandom_range(65535));
            end
            send_quat(q[0], q[1], q[2], q[3]);
        end
        idle_input();
    endtask

    initial
    begin
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        m_axis_tready  = 1'b0;
        error_count    = 0;
        send_idle_pct  = 0;
        sink_stall_pct = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_random(380, 0, 0, 1'b0);
        test_random(380, 59, 0, 1'b1);
        test_random(380, 0, 59, 1'b0);
        test_random(390, 22, 22, 1'b0);

        wait (angles_due.size() == 0);
        repeat (END_WAIT) @(posedge clk);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/q2e_pkg.sv
rtl/q2e_delay.sv
rtl/q2e_cordic_cell.sv
rtl/q2e_sqrt_cell.sv
rtl/q2e_atan.sv
rtl/quaternion_to_euler_angles.sv
rtl/q2e_checker.sv
sim/tb.sv
